// ===== design/fsk_bit_correlator_detector_unit_assert.svh =====
// assertion macros for the fsk correlator detector
// used by the top level; expects clk_i and rst_ni in scope
`ifndef FSK_BIT_CORRELATOR_DETECTOR_UNIT_ASSERT_SVH
`define FSK_BIT_CORRELATOR_DETECTOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FSKCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fskcd: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define FSKCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fskcd: next-cycle check failed");

`endif

// ===== design/fskcd_pkg.sv =====
// shared types, constants and tap roms for the fsk correlator detector
// no dependencies
package fskcd_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS  = 16;
  localparam int OFFSET_BITS  = 4;
  localparam int TAP_BITS     = 16;
  localparam int TAP_IDX_W    = 5;
  localparam int TAP_ROM_SIZE = 5;
  localparam int PROD_BITS    = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_BITS     = 36;
  localparam int TRUNC_SHIFT  = 4;
  localparam int SQ_IN_BITS   = 32;
  localparam int ENERGY_BITS  = 2 * SQ_IN_BITS;
  localparam int QUEUE_DEPTH  = 2;

  // defaults for the top level parameters
  localparam int DEF_BIT_PERIOD   = 9;
  localparam int DEF_SKIP_SAMPLES = 2;
  localparam int DEF_USED_SAMPLES = 5;

  // one correlation sample handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sr;
    logic signed [SAMPLE_BITS-1:0] si;
    logic [TAP_IDX_W-1:0]          tap;
    logic                          last;
  } fskcd_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fskcd_qstat_t;

  // cos(2*pi*85*i/900) in q1.14, zero beyond the rom
  function automatic logic signed [TAP_BITS-1:0] tap_cos(input logic [TAP_IDX_W-1:0] idx);
    logic signed [TAP_BITS-1:0] v;
    case (idx)
      5'd0:    v = 16'sd16384;
      5'd1:    v = 16'sd13583;
      5'd2:    v = 16'sd6138;
      5'd3:    v = -16'sd3406;
      5'd4:    v = -16'sd11786;
      default: v = '0;
    endcase
    return v;
  endfunction

  // sin(2*pi*85*i/900) in q1.14, zero beyond the rom
  function automatic logic signed [TAP_BITS-1:0] tap_sin(input logic [TAP_IDX_W-1:0] idx);
    logic signed [TAP_BITS-1:0] v;
    case (idx)
      5'd0:    v = 16'sd0;
      5'd1:    v = 16'sd9162;
      5'd2:    v = 16'sd15191;
      5'd3:    v = 16'sd16026;
      5'd4:    v = 16'sd11381;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/fskcd_front.sv =====
// front end: takes items, tracks sample phase and bit sync, picks the
// samples to correlate; depends on fskcd_pkg
module fskcd_front import fskcd_pkg::*; #(
  parameter int BIT_PERIOD   = DEF_BIT_PERIOD,
  parameter int SKIP_SAMPLES = DEF_SKIP_SAMPLES,
  parameter int USED_SAMPLES = DEF_USED_SAMPLES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  input  logic [OFFSET_BITS-1:0]        sync_offset_i,
  input  fskcd_qstat_t                  q_stat_i,
  output logic                          push_o,
  output fskcd_entry_t                  entry_o
);

  localparam int PH_W  = $clog2(BIT_PERIOD);
  localparam int CMP_W = (PH_W > OFFSET_BITS) ? PH_W : OFFSET_BITS;
  localparam int SK_W  = (SKIP_SAMPLES > 0) ? $clog2(SKIP_SAMPLES + 1) : 1;
  localparam int TAP_W = (USED_SAMPLES > 1) ? $clog2(USED_SAMPLES) : 1;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_SKIP = 2'd2;
  localparam logic [1:0] MODE_RECV = 2'd3;

  logic [PH_W-1:0]        phase_q, phase_d, phase_nx;
  logic [1:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] active_q, active_d, pending_q, pending_d;
  logic [SK_W-1:0]        skip_q, skip_d;
  logic [TAP_W-1:0]       tap_q, tap_d;
  logic                   accept;
  logic                   is_last;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_last    = (tap_q == TAP_W'(USED_SAMPLES - 1));

  // phase advances modulo the bit period
  assign phase_nx = (phase_q == PH_W'(BIT_PERIOD - 1)) ? '0 : phase_q + 1'b1;

  // sample entry for the back end
  assign entry_o.sr   = sample_real_i;
  assign entry_o.si   = sample_imag_i;
  assign entry_o.tap  = TAP_IDX_W'(tap_q);
  assign entry_o.last = is_last;

  // sync and classification
  always_comb begin
    logic [1:0]      m;
    logic [SK_W-1:0] sk;
    m         = mode_q;
    sk        = skip_q;
    phase_d   = phase_q;
    mode_d    = mode_q;
    active_d  = active_q;
    pending_d = pending_q;
    skip_d    = skip_q;
    tap_d     = tap_q;
    push_o    = 1'b0;
    if (accept) begin
      if (opcode_i) begin
        if (mode_q == MODE_IDLE) begin
          mode_d   = MODE_WAIT;
          active_d = sync_offset_i;
        end
        pending_d = sync_offset_i;
      end else begin
        phase_d = phase_nx;
        if (mode_q != MODE_IDLE) begin
          if (m == MODE_WAIT && CMP_W'(phase_nx) == CMP_W'(active_q)) begin
            m  = MODE_SKIP;
            sk = '0;
          end
          mode_d = m;
          skip_d = sk;
          case (m)
            MODE_SKIP: begin
              if (sk >= SK_W'(SKIP_SAMPLES)) begin
                mode_d = MODE_RECV;
                tap_d  = '0;
              end else begin
                skip_d = sk + 1'b1;
              end
            end
            MODE_RECV: begin
              push_o = 1'b1;
              if (is_last) begin
                mode_d   = MODE_WAIT;
                active_d = pending_q;
              end else begin
                tap_d = tap_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      mode_q    <= MODE_IDLE;
      active_q  <= '0;
      pending_q <= '0;
      skip_q    <= '0;
      tap_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      active_q  <= active_d;
      pending_q <= pending_d;
      skip_q    <= skip_d;
      tap_q     <= tap_d;
    end
  end

endmodule

// ===== design/fskcd_queue.sv =====
// two-entry item queue between front and back ends
// depends on fskcd_pkg
module fskcd_queue import fskcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  fskcd_entry_t entry_i,
  input  logic         pop_i,
  output fskcd_entry_t entry_o,
  output fskcd_qstat_t stat_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fskcd_entry_t     mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign entry_o      = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/fskcd_back.sv =====
// back end: one multiplier for the tone mixes, a squarer for the energy squares and
// the decision register; depends on fskcd_pkg
module fskcd_back import fskcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fskcd_qstat_t q_stat_i,
  input  fskcd_entry_t entry_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         bit_is_b_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SQ    = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] step_q, step_d;

  // current sample
  logic signed [SAMPLE_BITS-1:0] sr_q, si_q;
  logic [TAP_IDX_W-1:0]          tap_q;
  logic                          last_q;

  // product and square pipeline registers
  logic signed [PROD_BITS-1:0] p_q, p_d;
  logic [1:0]                  pstep_q;
  logic                        pv_q, pv_d;
  logic [ENERGY_BITS-1:0]      sq_q, sq_d;
  logic [1:0]                  sqstep_q;
  logic                        sv_q, sv_d;

  // accumulators and energies
  logic signed [ACC_BITS-1:0] bre_q, bim_q, yre_q, yim_q;
  logic signed [ACC_BITS-1:0] bre_d, bim_d, yre_d, yim_d;
  logic [ENERGY_BITS-1:0]     eb_q, ey_q, eb_d, ey_d;

  logic                          out_valid_q, out_bit_q, out_load;
  logic                          clear;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [TAP_BITS-1:0]    mul_t;
  logic signed [ACC_BITS-1:0]    p_ext, sq_sel;
  logic signed [SQ_IN_BITS-1:0]  trunc;
  logic [SQ_IN_BITS-1:0]         mag;

  assign out_valid_o = out_valid_q;
  assign bit_is_b_o  = out_bit_q;
  assign pop_o       = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign clear       = pop_o && (entry_i.tap == '0);

  // operand select: sr*c, si*s, sr*s, si*c
  assign mul_a = step_q[0] ? si_q : sr_q;
  assign mul_t = (step_q == 2'd0 || step_q == 2'd3) ? tap_cos(tap_q) : tap_sin(tap_q);
  assign p_d   = PROD_BITS'(mul_a * mul_t);
  assign pv_d  = (state_q == ST_MUL);
  assign p_ext = ACC_BITS'(p_q);

  // truncated magnitude for the energy square
  always_comb begin
    case (step_q)
      2'd0:    sq_sel = bre_q;
      2'd1:    sq_sel = bim_q;
      2'd2:    sq_sel = yre_q;
      default: sq_sel = yim_q;
    endcase
  end
  assign trunc = sq_sel[ACC_BITS-1:TRUNC_SHIFT];
  assign mag   = trunc[SQ_IN_BITS-1] ? SQ_IN_BITS'(~trunc + 1'b1) : SQ_IN_BITS'(trunc);
  assign sq_d  = ENERGY_BITS'(mag) * ENERGY_BITS'(mag);
  assign sv_d  = (state_q == ST_SQ);

  // accumulate the previous product into the tone mixes
  always_comb begin
    bre_d = bre_q;
    bim_d = bim_q;
    yre_d = yre_q;
    yim_d = yim_q;
    if (pv_q) begin
      case (pstep_q)
        2'd0: begin
          yre_d = yre_q + p_ext;
          bre_d = bre_q + p_ext;
        end
        2'd1: begin
          yre_d = yre_q - p_ext;
          bre_d = bre_q + p_ext;
        end
        2'd2: begin
          yim_d = yim_q + p_ext;
          bim_d = bim_q - p_ext;
        end
        default: begin
          yim_d = yim_q + p_ext;
          bim_d = bim_q + p_ext;
        end
      endcase
    end
    if (clear) begin
      bre_d = '0;
      bim_d = '0;
      yre_d = '0;
      yim_d = '0;
    end
  end

  // sum the squares into the two energies
  always_comb begin
    eb_d = eb_q;
    ey_d = ey_q;
    if (state_q == ST_DRAIN) begin
      eb_d = '0;
      ey_d = '0;
    end else if (sv_q) begin
      if (sqstep_q[1]) begin
        ey_d = ey_q + sq_q;
      end else begin
        eb_d = eb_q + sq_q;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_MUL;
          step_d  = '0;
        end
      end
      ST_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) begin
          state_d = last_q ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SQ;
        step_d  = '0;
      end
      ST_SQ: begin
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pv_q        <= 1'b0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pv_q    <= pv_d;
      sv_q    <= sv_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sr_q   <= entry_i.sr;
      si_q   <= entry_i.si;
      tap_q  <= entry_i.tap;
      last_q <= entry_i.last;
    end
    p_q      <= p_d;
    pstep_q  <= step_q;
    sq_q     <= sq_d;
    sqstep_q <= step_q;
    bre_q    <= bre_d;
    bim_q    <= bim_d;
    yre_q    <= yre_d;
    yim_q    <= yim_d;
    eb_q     <= eb_d;
    ey_q     <= ey_d;
    if (out_load) begin
      out_bit_q <= (eb_q > ey_q);
    end
  end

endmodule

// ===== design/fsk_bit_correlator_detector_unit.sv =====
// Noncoherent FSK bit detector. Items carry either a complex baseband sample
// (opcode 0) or a bit-sync offset (opcode 1). The front end takes one item per
// cycle whenever its two-entry queue has room; each correlation sample is then
// loaded in the back end and put through four products on a single 16x16
// multiplier, and a bit decision adds four 32x32 energy squares on one
// squarer, the final sum and the compare. At the default parameters one bit
// spans 9 samples. Decisions wait in an output register; in_stall_o rises only
// when the queue is full. Ties between the two tone energies decide Y
// (bit_is_b_o low).
// top level; depends on fskcd_pkg, fskcd_front, fskcd_queue, fskcd_back
module fsk_bit_correlator_detector_unit import fskcd_pkg::*; #(
  parameter int BIT_PERIOD   = DEF_BIT_PERIOD,
  parameter int SKIP_SAMPLES = DEF_SKIP_SAMPLES,
  parameter int USED_SAMPLES = DEF_USED_SAMPLES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  input  logic [OFFSET_BITS-1:0]        sync_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          bit_is_b_o
);

  fskcd_qstat_t q_stat;
  fskcd_entry_t fr_entry, q_entry;
  logic         fr_push, bk_pop;

  // item classification and bit sync
  fskcd_front #(
    .BIT_PERIOD  (BIT_PERIOD),
    .SKIP_SAMPLES(SKIP_SAMPLES),
    .USED_SAMPLES(USED_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .sample_real_i(sample_real_i),
    .sample_imag_i(sample_imag_i),
    .sync_offset_i(sync_offset_i),
    .q_stat_i     (q_stat),
    .push_o       (fr_push),
    .entry_o      (fr_entry)
  );

  // decoupling queue
  fskcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_push),
    .entry_i(fr_entry),
    .pop_i  (bk_pop),
    .entry_o(q_entry),
    .stat_o (q_stat)
  );

  // correlation and decision
  fskcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .entry_i    (q_entry),
    .pop_o      (bk_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .bit_is_b_o (bit_is_b_o)
  );

  // checks on the queue hand-off
  `include "fsk_bit_correlator_detector_unit_assert.svh"

  `FSKCD_ASSERT_NOW(a_push_has_room, fr_push, !q_stat.full)
  `FSKCD_ASSERT_NOW(a_pop_has_item, bk_pop, !q_stat.empty)
  `FSKCD_ASSERT_NEXT(a_full_holds_stall, q_stat.full && !bk_pop, in_stall_o)

endmodule
